[design/tkl_pkg.sv]
package tkl_pkg;

  localparam int LIST_CAPACITY      = 256;
  localparam int GROUP_SIZE         = 16;
  localparam int NUM_GROUPS         = LIST_CAPACITY / GROUP_SIZE;
  localparam int NUM_QUARTERS       = 4;
  localparam int GROUPS_PER_QUARTER = NUM_GROUPS / NUM_QUARTERS;

  localparam int DIST_W  = 24;
  localparam int NODE_W  = 20;
  localparam int RANK_W  = 8;
  localparam int CNT_W   = 9;
  localparam int LIMIT_W = 9;
  localparam int SEL_W   = $clog2(GROUP_SIZE);
  localparam int GRP_W   = $clog2(NUM_GROUPS);
  localparam int GCNT_W  = $clog2(GROUP_SIZE + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(200);
  localparam logic [CNT_W-1:0]   CAP_COUNT   = CNT_W'(LIST_CAPACITY);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_PRUNE  = 2'd3
  } tkl_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_CNT,
    ST_SUM,
    ST_FIN
  } tkl_state_t;

  typedef struct packed {
    tkl_cmd_t          command;
    logic [DIST_W-1:0] distance;
    logic [NODE_W-1:0] node_id;
    logic [RANK_W-1:0] rank_index;
  } tkl_in_t;

  typedef struct packed {
    logic              accepted;
    logic [RANK_W-1:0] placed_rank;
    logic [DIST_W-1:0] entry_distance;
    logic [NODE_W-1:0] entry_node;
    logic              entry_valid;
    logic [CNT_W-1:0]  entry_count;
    logic              beyond_worst;
  } tkl_out_t;

  typedef struct packed {
    logic [DIST_W-1:0] key;
    logic [NODE_W-1:0] node;
  } tkl_entry_t;

  typedef struct packed {
    logic cmp_en;
    logic commit;
  } tkl_cell_ctrl_t;

endpackage

[design/tkl_cell.sv]
module tkl_cell (
  input  logic                    clk,
  input  tkl_pkg::tkl_cell_ctrl_t ctrl,
  input  tkl_pkg::tkl_entry_t     cand,
  input  logic                    valid,
  input  tkl_pkg::tkl_entry_t     left_entry,
  input  logic                    left_le,
  output tkl_pkg::tkl_entry_t     entry,
  output logic                    le
);
  import tkl_pkg::*;

  tkl_entry_t entry_r;
  logic       le_r;

  // le_r: this slot holds a live entry no farther than the candidate
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      le_r <= valid && (entry_r.key <= cand.key);
    end
    // keep if no farther; otherwise take the candidate or shift in from the left
    if (ctrl.commit && !le_r) begin
      entry_r <= left_le ? cand : left_entry;
    end
  end

  assign entry = entry_r;
  assign le    = le_r;

endmodule

[design/tkl_group.sv]
module tkl_group (
  input  logic                          clk,
  input  tkl_pkg::tkl_cell_ctrl_t       ctrl,
  input  tkl_pkg::tkl_entry_t           cand,
  input  logic [tkl_pkg::CNT_W-1:0]     cnt,
  input  logic [tkl_pkg::GRP_W-1:0]     grp_idx,
  input  logic [tkl_pkg::SEL_W-1:0]     rd_sel,
  input  tkl_pkg::tkl_entry_t           left_entry,
  input  logic                          left_le,
  output tkl_pkg::tkl_entry_t           right_entry,
  output logic                          right_le,
  output logic [tkl_pkg::GCNT_W-1:0]    le_cnt,
  output tkl_pkg::tkl_entry_t           rd_entry
);
  import tkl_pkg::*;

  tkl_entry_t              ent [GROUP_SIZE];
  logic [GROUP_SIZE-1:0]   le_vec;
  logic [GCNT_W-1:0]       le_cnt_r;
  tkl_entry_t              rd_entry_r;

  for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_cell
    logic       valid;
    tkl_entry_t l_ent;
    logic       l_le;

    assign valid = CNT_W'({grp_idx, SEL_W'(j)}) < cnt;

    if (j == 0) begin : g_first
      assign l_ent = left_entry;
      assign l_le  = left_le;
    end else begin : g_rest
      assign l_ent = ent[j-1];
      assign l_le  = le_vec[j-1];
    end

    tkl_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cand       (cand),
      .valid      (valid),
      .left_entry (l_ent),
      .left_le    (l_le),
      .entry      (ent[j]),
      .le         (le_vec[j])
    );
  end

  // per-group partial count and first read stage, one register level each
  always_ff @(posedge clk) begin
    le_cnt_r   <= GCNT_W'($countones(le_vec));
    rd_entry_r <= ent[rd_sel];
  end

  assign right_entry = ent[GROUP_SIZE-1];
  assign right_le    = le_vec[GROUP_SIZE-1];
  assign le_cnt      = le_cnt_r;
  assign rd_entry    = rd_entry_r;

endmodule

[design/bounded_sorted_topk_list.sv]
// Sorted top-k result list: keeps up to list_limit (1..256, 0 acts as 1, larger
// values act as 256) pairs of (distance, node id) in ascending distance order,
// ties in arrival order. Each item carries one command (clear, insert, read by
// rank, prune test) and gives exactly one result item. The entries live in a
// row of 256 cells grouped by 16; an insert is a single shift along the row.
// An item passes through these steps from acceptance to its registered result:
// all cells compare against the candidate, the per-cell compare bits are
// reduced to a placement rank (per-group count, then quarter sums), and a
// final step commits the shift and loads the result. The next item is taken
// only once the block is back in idle, so a new item is not accepted before
// the last result is loaded; a result that is not taken holds the block in
// its final state. No clearing pass runs after reset: the fill count alone
// decides which entries are live.
module bounded_sorted_topk_list (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tkl_pkg::tkl_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tkl_pkg::tkl_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [tkl_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import tkl_pkg::*;

  tkl_state_t          state_r, state_nxt;
  tkl_in_t             req_r;
  logic [RANK_W-1:0]   addr_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LIMIT_W-1:0]  lim_r;
  logic [CNT_W-1:0]    psum_r [NUM_QUARTERS];
  tkl_entry_t          ent_r;
  logic                out_valid_r;
  tkl_out_t            out_r;

  logic [CNT_W-1:0]    lim_eff;
  logic [CNT_W-1:0]    pos;
  logic [CNT_W:0]      cnt_inc;
  logic [CNT_W-1:0]    new_cnt;
  logic                ins_ok;
  logic                in_fire;
  logic                fin_fire;
  tkl_cell_ctrl_t      cell_ctrl;
  tkl_entry_t          cand;
  tkl_out_t            res;

  tkl_entry_t          chain_ent [NUM_GROUPS];
  logic                chain_le  [NUM_GROUPS];
  logic [GCNT_W-1:0]   grp_cnt   [NUM_GROUPS];
  tkl_entry_t          grp_rd    [NUM_GROUPS];

  assign cand.key  = req_r.distance;
  assign cand.node = req_r.node_id;

  // clamp the written limit into 1..capacity
  always_comb begin
    priority if (lim_r == '0) begin
      lim_eff = CNT_W'(1);
    end else if (CNT_W'(lim_r) > CAP_COUNT) begin
      lim_eff = CAP_COUNT;
    end else begin
      lim_eff = CNT_W'(lim_r);
    end
  end

  // cell row, chained group to group
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    tkl_entry_t l_ent;
    logic       l_le;

    if (g == 0) begin : g_head
      // the head of the row sees "left is nearer", so it takes the candidate
      assign l_ent = cand;
      assign l_le  = 1'b1;
    end else begin : g_link
      assign l_ent = chain_ent[g-1];
      assign l_le  = chain_le[g-1];
    end

    tkl_group u_group (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .cand        (cand),
      .cnt         (cnt_r),
      .grp_idx     (GRP_W'(g)),
      .rd_sel      (addr_r[SEL_W-1:0]),
      .left_entry  (l_ent),
      .left_le     (l_le),
      .right_entry (chain_ent[g]),
      .right_le    (chain_le[g]),
      .le_cnt      (grp_cnt[g]),
      .rd_entry    (grp_rd[g])
    );
  end

  // placement rank from the quarter sums
  always_comb begin
    pos = '0;
    for (int q = 0; q < NUM_QUARTERS; q++) begin
      pos = pos + psum_r[q];
    end
  end

  assign ins_ok  = (req_r.command == CMD_INSERT) && (pos < lim_eff);
  assign cnt_inc = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign new_cnt = (cnt_inc < {1'b0, lim_eff}) ? cnt_inc[CNT_W-1:0] : lim_eff;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_CNT;
      ST_CNT:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready         = 1'b0;
    fin_fire         = 1'b0;
    cell_ctrl.cmp_en = 1'b0;
    cell_ctrl.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_CMP:  cell_ctrl.cmp_en = 1'b1;
      ST_CNT,
      ST_SUM:  ;
      ST_FIN: begin
        fin_fire         = !out_valid_r || out_ready;
        cell_ctrl.commit = fin_fire && ins_ok;
      end
      default: ;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // fill count after this item
  always_comb begin
    cnt_nxt = cnt_r;
    if (fin_fire) begin
      if (req_r.command == CMD_CLEAR) begin
        cnt_nxt = '0;
      end else if (ins_ok) begin
        cnt_nxt = new_cnt;
      end
    end
  end

  // result fields; fields a command does not produce stay zero
  always_comb begin
    res             = '0;
    res.entry_count = cnt_nxt;
    unique case (req_r.command)
      CMD_CLEAR: ;
      CMD_INSERT: begin
        if (ins_ok) begin
          res.accepted    = 1'b1;
          res.placed_rank = pos[RANK_W-1:0];
        end
      end
      CMD_READ: begin
        if (CNT_W'(req_r.rank_index) < cnt_r) begin
          res.entry_valid    = 1'b1;
          res.entry_distance = ent_r.key;
          res.entry_node     = ent_r.node;
        end
      end
      CMD_PRUNE: begin
        res.beyond_worst = (cnt_r >= lim_eff) && (cnt_r != '0) &&
                           (req_r.distance > ent_r.key);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      lim_r       <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
      // read uses the asked rank; the prune test looks at the worst entry
      addr_r <= (in_data.command == CMD_READ) ? in_data.rank_index
                                               : RANK_W'(cnt_r - CNT_W'(1));
    end
    // second read stage: pick the group
    ent_r <= grp_rd[addr_r[RANK_W-1:SEL_W]];
    if (fin_fire) begin
      out_r <= res;
    end
  end

  // quarter sums of the per-group counts
  logic [CNT_W-1:0] qsum [NUM_QUARTERS];

  always_comb begin
    for (int q = 0; q < NUM_QUARTERS; q++) begin
      qsum[q] = '0;
      for (int k = 0; k < GROUPS_PER_QUARTER; k++) begin
        qsum[q] = qsum[q] + CNT_W'(grp_cnt[q*GROUPS_PER_QUARTER + k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int q = 0; q < NUM_QUARTERS; q++) begin
      psum_r[q] <= qsum[q];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
